// ----- design/signed_int_to_radix_string_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the signed integer to radix text block.
// Both macros sample on clk_i and are disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_RADIX_STRING_DEFINES_SVH
`define SIGNED_INT_TO_RADIX_STRING_DEFINES_SVH

// Checks that a condition holds on every clock edge.
`define SIRS_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

// Checks that a trigger is followed by a consequence in the next cycle.
`define SIRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/sirs_pkg.sv -----
// ----------------------------------------------------------------------------
// sirs_pkg
// Types, constants and helper functions shared by the radix text converter.
// ----------------------------------------------------------------------------
package sirs_pkg;

  localparam int unsigned ValueBits    = 32;
  localparam int unsigned RadixBits    = 6;
  localparam int unsigned CharBits     = 8;
  localparam int unsigned MaxDigits    = 32;
  localparam int unsigned PtrBits      = $clog2(MaxDigits);
  localparam int unsigned RadixMin     = 2;
  localparam int unsigned RadixMax     = 36;
  localparam int unsigned RadixDefault = 10;

  typedef logic [ValueBits-1:0] word_t;
  typedef logic [RadixBits-1:0] radix_t;
  typedef logic [CharBits-1:0]  char_t;
  typedef logic [PtrBits-1:0]   ptr_t;

  localparam char_t CharMinus  = 8'h2d;
  localparam char_t CharZero   = 8'h30;
  localparam char_t CharLowerA = 8'h61;

  // Reciprocal table: floor(2^32 / b) for each radix b; unused slots are zero.
  localparam logic [ValueBits:0] TwoPow32 = 33'h1_0000_0000;
  localparam word_t RecipTable [RadixMax+1] = '{
    32'd0,                  32'd0,
    32'(TwoPow32 / 33'd2),  32'(TwoPow32 / 33'd3),  32'(TwoPow32 / 33'd4),
    32'(TwoPow32 / 33'd5),  32'(TwoPow32 / 33'd6),  32'(TwoPow32 / 33'd7),
    32'(TwoPow32 / 33'd8),  32'(TwoPow32 / 33'd9),  32'(TwoPow32 / 33'd10),
    32'(TwoPow32 / 33'd11), 32'(TwoPow32 / 33'd12), 32'(TwoPow32 / 33'd13),
    32'(TwoPow32 / 33'd14), 32'(TwoPow32 / 33'd15), 32'(TwoPow32 / 33'd16),
    32'(TwoPow32 / 33'd17), 32'(TwoPow32 / 33'd18), 32'(TwoPow32 / 33'd19),
    32'(TwoPow32 / 33'd20), 32'(TwoPow32 / 33'd21), 32'(TwoPow32 / 33'd22),
    32'(TwoPow32 / 33'd23), 32'(TwoPow32 / 33'd24), 32'(TwoPow32 / 33'd25),
    32'(TwoPow32 / 33'd26), 32'(TwoPow32 / 33'd27), 32'(TwoPow32 / 33'd28),
    32'(TwoPow32 / 33'd29), 32'(TwoPow32 / 33'd30), 32'(TwoPow32 / 33'd31),
    32'(TwoPow32 / 33'd32), 32'(TwoPow32 / 33'd33), 32'(TwoPow32 / 33'd34),
    32'(TwoPow32 / 33'd35), 32'(TwoPow32 / 33'd36)
  };

  // Sequencer states.
  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StWait,
    StEmit
  } sirs_state_e;

  // Request into the shared divide unit.
  typedef struct packed {
    logic   start;
    word_t  dividend;
    radix_t radix;
  } div_req_t;

  // Response from the shared divide unit.
  typedef struct packed {
    logic   done;
    word_t  quot;
    radix_t rem;
  } div_rsp_t;

  // Maps an out-of-range radix to the default base.
  function automatic radix_t norm_radix(radix_t r);
    if ((r < radix_t'(RadixMin)) || (r > radix_t'(RadixMax))) begin
      return radix_t'(RadixDefault);
    end
    return r;
  endfunction

  // Looks up the reciprocal of a normalized radix.
  function automatic word_t recip_of(radix_t r);
    if (r > radix_t'(RadixMax)) begin
      return '0;
    end
    return RecipTable[r];
  endfunction

  // Converts a digit value to its ASCII character.
  function automatic char_t digit_char(radix_t d);
    if (d < radix_t'(RadixDefault)) begin
      return CharZero + char_t'(d);
    end
    return CharLowerA + char_t'(d) - char_t'(RadixDefault);
  endfunction

endpackage

// ----- design/sirs_divider.sv -----
// ----------------------------------------------------------------------------
// sirs_divider
// Divide by a small radix using a reciprocal multiply and one
// correction step. The result is valid in the cycle after start.
// ----------------------------------------------------------------------------
module sirs_divider import sirs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                     busy_q;
  logic [2*ValueBits-1:0]   prod_q;
  word_t                    dividend_q;
  radix_t                   radix_q;

  word_t                    q_est;
  logic [ValueBits+RadixBits-1:0] q_times_b;
  word_t                    diff;
  logic [RadixBits:0]       rem_wide;

  // Done flag is a registered copy of start.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= req_i.start;
    end
  end

  // Registered step: multiply the dividend by the reciprocal of the radix.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      prod_q     <= {{ValueBits{1'b0}}, req_i.dividend} *
                    {{ValueBits{1'b0}}, recip_of(req_i.radix)};
      dividend_q <= req_i.dividend;
      radix_q    <= req_i.radix;
    end
  end

  // Combinational step: the estimate is low by at most one, so one compare fixes it.
  always_comb begin
    q_est     = prod_q[2*ValueBits-1:ValueBits];
    q_times_b = {{RadixBits{1'b0}}, q_est} * {{ValueBits{1'b0}}, radix_q};
    diff      = dividend_q - q_times_b[ValueBits-1:0];
    rem_wide  = diff[RadixBits:0];
    rsp_o.done = busy_q;
    if (rem_wide >= {1'b0, radix_q}) begin
      rsp_o.quot = q_est + word_t'(1);
      rsp_o.rem  = radix_t'(rem_wide - {1'b0, radix_q});
    end else begin
      rsp_o.quot = q_est;
      rsp_o.rem  = rem_wide[RadixBits-1:0];
    end
  end

endmodule

// ----- design/signed_int_to_radix_string.sv -----
// ----------------------------------------------------------------------------
// signed_int_to_radix_string
// Converts a signed 32-bit integer to ASCII text in radix 2 to 36, one
// character per output beat, sign first, then digits most significant first.
// Each digit takes a divide state and a wait state of the shared reciprocal
// divide unit. Once all digits are stored, the characters leave one per
// cycle while the output is not stalled. A new input beat is taken once the
// last character is in the output register. Reset clears all control state.
// ----------------------------------------------------------------------------
`include "signed_int_to_radix_string_defines.svh"

module signed_int_to_radix_string import sirs_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [ValueBits-1:0] value_i,
  input  logic [RadixBits-1:0]        radix_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [CharBits-1:0]         text_char_o,
  output logic                        last_o
);

  sirs_state_e state_q, state_d;
  logic        neg_q;
  logic        sign_pending_q;
  ptr_t        ptr_q;
  word_t       mag_q;
  radix_t      radix_q;
  radix_t      digits_q [MaxDigits];
  logic        out_valid_q;
  char_t       text_char_q;
  logic        last_q;

  div_req_t    div_req;
  div_rsp_t    rsp;
  logic        in_accept;
  logic        push;
  logic        digits_done;
  logic        out_free;
  logic        emit_load;
  word_t       value_u;

  // Shared divide unit.
  sirs_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (rsp)
  );

  assign value_u     = word_t'(value_i);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign digits_done = (rsp.quot == '0) || (ptr_q == ptr_t'(MaxDigits - 1));

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StDiv;
      end
      StDiv: begin
        state_d = StWait;
      end
      StWait: begin
        if (rsp.done) state_d = digits_done ? StEmit : StDiv;
      end
      StEmit: begin
        if (out_free && !sign_pending_q && (ptr_q == '0)) state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_stall_o       = (state_q != StIdle);
    in_accept        = in_valid_i && (state_q == StIdle);
    div_req.start    = (state_q == StDiv);
    div_req.dividend = mag_q;
    div_req.radix    = radix_q;
    push             = (state_q == StWait) && rsp.done;
    emit_load        = (state_q == StEmit) && out_free;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      neg_q          <= 1'b0;
      sign_pending_q <= 1'b0;
      ptr_q          <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        neg_q          <= value_u[ValueBits-1];
        sign_pending_q <= value_u[ValueBits-1];
        ptr_q          <= '0;
      end else if (push) begin
        if (!digits_done) ptr_q <= ptr_q + ptr_t'(1);
      end else if (emit_load) begin
        if (sign_pending_q) begin
          sign_pending_q <= 1'b0;
        end else if (ptr_q != '0) begin
          ptr_q <= ptr_q - ptr_t'(1);
        end
      end
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Magnitude and radix of the item being converted.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mag_q   <= value_u[ValueBits-1] ? (~value_u + word_t'(1)) : value_u;
      radix_q <= norm_radix(radix_i);
    end else if (push) begin
      mag_q <= rsp.quot;
    end
  end

  // Digit stack, filled least significant first and read back from the top.
  always_ff @(posedge clk_i) begin
    if (push) begin
      digits_q[ptr_q] <= rsp.rem;
    end
  end

  // Output register for the character beat.
  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      if (sign_pending_q) begin
        text_char_q <= CharMinus;
        last_q      <= 1'b0;
      end else begin
        text_char_q <= digit_char(digits_q[ptr_q]);
        last_q      <= (ptr_q == '0);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign text_char_o = text_char_q;
  assign last_o      = last_q;

  // The divide unit answers in the cycle after each start.
  `SIRS_ASSERT_NEXT(a_div_done, div_req.start, rsp.done, "divider did not answer")
  // A pending sign character exists only for negative values.
  `SIRS_ASSERT(a_sign_neg, !sign_pending_q || neg_q, "sign pending on positive value")
  // An accepted input beat starts a division.
  `SIRS_ASSERT_NEXT(a_accept_div, in_valid_i && !in_stall_o, state_q == StDiv,
                    "accepted beat did not start a division")

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the signed integer to radix text converter.
// A short table of directed numbers covers zero, the integer extremes, the
// smallest and largest radix and the out-of-range radix values. Random numbers
// follow in three phases of sender and receiver idling. Every output beat is
// compared with the text queued for each accepted input, from the table or predicted.
// ----------------------------------------------------------------------------
module tb import sirs_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DirRows       = 24;
  localparam int RandomPerPass = 65;
  localparam int StuckLimit    = 2000;
  localparam int DrainCycles   = 120;
  localparam int MaxReports    = 10;

  // One expected output beat.
  typedef struct packed {
    char_t ch;
    logic  last;
  } text_beat_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic signed [31:0]   value_i     = '0;
  logic [RadixBits-1:0] radix_i     = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [CharBits-1:0]  text_char_o;
  logic                 last_o;

  text_beat_t pending_chars [$];
  int         mismatches     = 0;
  int         stuck_cycles   = 0;
  int         recv_stall_pct = 0;

  // Directed numbers. An empty text means the row is checked by prediction.
  logic [31:0] dir_value [DirRows] = '{
    32'd0,          32'd0,          32'h8000_0000,  32'h7fff_ffff,
    32'h8000_0000,  32'h7fff_ffff,  32'hffff_ffff,  32'hffff_ffff,
    32'd35,         32'd36,         32'h7fff_ffff,  32'h8000_0000,
    32'd255,        32'h8000_0000,  32'd123,        32'd123,
    -32'sd45,       32'd99,         32'd8,          32'h7fff_ffff,
    32'h8000_0000,  32'd1000,       32'd5,          -32'sd12345
  };
  logic [RadixBits-1:0] dir_radix [DirRows] = '{
    6'd10, 6'd2,  6'd10, 6'd10,
    6'd2,  6'd2,  6'd2,  6'd36,
    6'd36, 6'd36, 6'd36, 6'd36,
    6'd16, 6'd16, 6'd0,  6'd1,
    6'd37, 6'd63, 6'd8,  6'd8,
    6'd3,  6'd7,  6'd2,  6'd35
  };
  string dir_text [DirRows] = '{
    "0",         "0",          "-2147483648", "2147483647",
    "",          "",           "-1",          "-1",
    "z",         "10",         "zik0zj",      "-zik0zk",
    "ff",        "-80000000",  "123",         "123",
    "-45",       "99",         "10",          "17777777777",
    "",          "",           "101",         ""
  };

  signed_int_to_radix_string u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .radix_i     (radix_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .text_char_o (text_char_o),
    .last_o      (last_o)
  );

  // Free-running clock, 20 ns period.
  always begin
    clk_i = 1'b0;
    #10ns;
    clk_i = 1'b1;
    #10ns;
  end

  // Queues one beat per character; the final character carries last.
  function automatic void queue_text(string txt);
    text_beat_t b;
    for (int i = 0; i < txt.len(); i++) begin
      b.ch   = char_t'(txt[i]);
      b.last = (i == txt.len() - 1);
      pending_chars.push_back(b);
    end
  endfunction

  // Builds the radix text of a number and queues its beats.
  function automatic void predict_radix_text(logic [31:0] num, logic [RadixBits-1:0] rad);
    string       numerals;
    string       txt;
    logic [31:0] mag;
    int unsigned base;
    int unsigned d;
    numerals = "0123456789abcdefghijklmnopqrstuvwxyz";
    txt      = "";
    base     = ((rad < 2) || (rad > 36)) ? 10 : int'(rad);
    // The magnitude is unsigned, so the most negative number needs no care.
    mag      = num[31] ? (~num + 32'd1) : num;
    do begin
      d   = mag % base;
      txt = {numerals.substr(d, d), txt};
      mag = mag / base;
    end while (mag != 0);
    if (num[31]) begin
      txt = {"-", txt};
    end
    queue_text(txt);
  endfunction

  task automatic report(string msg);
    if (mismatches < MaxReports) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  // Offers one number after a random gap and waits until it is taken.
  task automatic offer_number(logic [31:0] num, logic [RadixBits-1:0] rad,
                              int send_idle_pct, string txt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= num;
    radix_i    <= rad;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    if (txt.len() != 0) begin
      queue_text(txt);
    end else begin
      predict_radix_text(num, rad);
    end
  endtask

  // Holds the input back until every queued character has come out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_chars.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Random numbers, mostly legal radix values, with a mix of magnitudes.
  task automatic run_random(int send_idle_pct, int recv_idle_pct);
    logic [31:0]          num;
    logic [RadixBits-1:0] rad;
    recv_stall_pct = recv_idle_pct;
    for (int i = 0; i < RandomPerPass; i++) begin
      case ($urandom_range(4))
        0: num = $urandom_range(40);
        1: num = -$urandom_range(40);
        2: begin
          case ($urandom_range(4))
            0: num = 32'h8000_0000;
            1: num = 32'h7fff_ffff;
            2: num = 32'hffff_ffff;
            3: num = 32'd1;
            default: num = 32'd0;
          endcase
        end
        3: num = $urandom >> $urandom_range(31);
        default: num = $urandom;
      endcase
      if ($urandom_range(99) < 85) begin
        rad = $urandom_range(36, 2);
      end else begin
        rad = $urandom_range(63);
      end
      offer_number(num, rad, send_idle_pct, "");
    end
  endtask

  // Receiver stall, redrawn every cycle.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Compares each output beat with the oldest queued character.
  always @(posedge clk_i) begin
    text_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_chars.size() == 0) begin
        report($sformatf("unexpected beat char=%02h last=%0b", text_char_o, last_o));
      end else begin
        want = pending_chars.pop_front();
        if (text_char_o !== want.ch || last_o !== want.last) begin
          report($sformatf("char expected %02h got %02h, last expected %0b got %0b",
                           want.ch, text_char_o, want.last, last_o));
        end
      end
    end
  end

  // Counts cycles in which neither channel moves a beat.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    while (stuck_cycles < StuckLimit) begin
      @(posedge clk_i);
    end
    $display("[%0t] ERROR: no beat moved for %0d cycles", $realtime, StuckLimit);
    $display("Simulation FAILED");
    $finish;
  end

  // Main sequence.
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, no idling on either side.
    for (int i = 0; i < DirRows; i++) begin
      offer_number(dir_value[i], dir_radix[i], 0, dir_text[i]);
    end
    wait_drained();

    // Random phases: receiver stalls more, then sender idles more, then neither.
    run_random(32, 54);
    wait_drained();
    run_random(54, 32);
    wait_drained();
    run_random(0, 0);
    wait_drained();

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/sirs_pkg.sv
design/sirs_divider.sv
design/signed_int_to_radix_string.sv
tb/tb.sv
